>>> rtl/core/wrh_pkg.sv
// Shared types, constants and helpers of the weighted RGB histogram.
// No dependencies.
package wrh_pkg;

  localparam int MAX_BPC   = 5;
  localparam int SUM_W     = 48;
  localparam int ADDR_W    = 3 * MAX_BPC;
  localparam int CHAN_W    = 24;
  localparam int WEIGHT_W  = 32;
  localparam int CENTER_W  = 16;
  localparam int CHAN_MAX  = 65470;

  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] BPC_RESET = 3'd4;

  typedef struct packed {
    logic [1:0]                  op;
    logic signed [CHAN_W-1:0]    red;
    logic signed [CHAN_W-1:0]    green;
    logic signed [CHAN_W-1:0]    blue;
    logic signed [WEIGHT_W-1:0]  weight;
    logic [ADDR_W-1:0]           bin_index;
  } item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]     bin_weight;
    logic [CENTER_W-1:0]         center_red;
    logic [CENTER_W-1:0]         center_green;
    logic [CENTER_W-1:0]         center_blue;
    logic                        saturated;
  } result_t;

  // Out-of-range register values fold to the nearest legal setting.
  function automatic logic [2:0] eff_bpc(input logic [2:0] bpc);
    logic [2:0] b;
    b = bpc;
    if (bpc == 3'd0) b = 3'd1;
    if (bpc > 3'(MAX_BPC)) b = 3'(MAX_BPC);
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] code_mask(input logic [2:0] bpc);
    return ADDR_W'((16'd1 << bpc) - 16'd1);
  endfunction

  // (2*code + 1) << (15 - bpc)
  function automatic logic [CENTER_W-1:0] center_q16(input logic [ADDR_W-1:0] code,
                                                      input logic [2:0] bpc);
    logic [CENTER_W-1:0] odd;
    odd = CENTER_W'({code, 1'b1});
    return CENTER_W'(odd << (5'd15 - 5'(bpc)));
  endfunction

endpackage

>>> rtl/core/wrh_bin_index.sv
// Clamps the three color channels and packs their top bits into a bin index.
// Depends on wrh_pkg.
module wrh_bin_index (
  input  logic signed [wrh_pkg::CHAN_W-1:0] red,
  input  logic signed [wrh_pkg::CHAN_W-1:0] green,
  input  logic signed [wrh_pkg::CHAN_W-1:0] blue,
  input  logic [2:0]                        bpc,
  output logic [wrh_pkg::ADDR_W-1:0]        index
);

  function automatic logic [wrh_pkg::ADDR_W-1:0] chan_code(
      input logic signed [wrh_pkg::CHAN_W-1:0] c, input logic [2:0] b);
    logic [15:0] cl;
    cl = c[15:0];
    if (c[wrh_pkg::CHAN_W-1]) cl = 16'd0;
    else if (c > wrh_pkg::CHAN_W'(wrh_pkg::CHAN_MAX)) cl = 16'(wrh_pkg::CHAN_MAX);
    return wrh_pkg::ADDR_W'(cl >> (5'd16 - 5'(b)));
  endfunction

  logic [wrh_pkg::ADDR_W-1:0] code_r, code_g, code_b;

  always_comb begin
    code_r = chan_code(red, bpc);
    code_g = chan_code(green, bpc);
    code_b = chan_code(blue, bpc);
    index  = (code_r << (4'(bpc) << 1)) | (code_g << bpc) | code_b;
  end

endmodule

>>> rtl/core/weighted_rgb_histogram.sv
// Top level of the weighted RGB histogram: bin memory, read-modify-write and clear sweep.
// Depends on wrh_pkg and wrh_bin_index.
// Accumulate and read items run the memory read, then the modify/write cycle;
// an unused op code leaves the block idle. A read result strobes for one cycle after the modify cycle.
// Reset and a clear item run a sweep over all 32768 bins (one bin per cycle), busy throughout.
// Synchronous active-high reset; the channel-bit register resets to 4.
module weighted_rgb_histogram (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  wrh_pkg::item_t  in_item,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_wdata,
  output logic            result_valid,
  output wrh_pkg::result_t result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MOD   = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  localparam logic signed [wrh_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(wrh_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [wrh_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(wrh_pkg::SUM_W-1){1'b0}}};

  logic [1:0] state, state_next;
  logic [2:0] bpc_reg;
  logic [2:0] bpc;
  logic       sat_flag;

  logic [wrh_pkg::SUM_W-1:0] mem [2**wrh_pkg::ADDR_W];
  logic [wrh_pkg::SUM_W-1:0] mem_q;
  logic [wrh_pkg::ADDR_W-1:0] rd_addr;
  logic                       wr_en;
  logic [wrh_pkg::ADDR_W-1:0] wr_addr;
  logic [wrh_pkg::SUM_W-1:0]  wr_data;

  logic [wrh_pkg::ADDR_W-1:0] acc_index;
  logic [wrh_pkg::ADDR_W-1:0] clr_addr;
  logic [wrh_pkg::ADDR_W-1:0] idx;
  logic                       is_read;
  logic                       in_range;
  logic signed [wrh_pkg::WEIGHT_W-1:0] weight;
  logic [wrh_pkg::CENTER_W-1:0] cen_r, cen_g, cen_b;

  logic signed [wrh_pkg::SUM_W:0] sum_wide;
  logic signed [wrh_pkg::SUM_W-1:0] sum_sat;
  logic                             overflow;
  logic                             accept;

  assign bpc    = wrh_pkg::eff_bpc(bpc_reg);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  wrh_bin_index u_bin_index (
    .red   (in_item.red),
    .green (in_item.green),
    .blue  (in_item.blue),
    .bpc   (bpc),
    .index (acc_index)
  );

  always_comb begin
    rd_addr = (in_item.op == wrh_pkg::OP_ACC) ? acc_index : in_item.bin_index;
  end

  always_comb begin
    sum_wide = $signed({mem_q[wrh_pkg::SUM_W-1], mem_q})
             + (wrh_pkg::SUM_W+1)'(weight);
    overflow = sum_wide[wrh_pkg::SUM_W] != sum_wide[wrh_pkg::SUM_W-1];
    if (!overflow) sum_sat = sum_wide[wrh_pkg::SUM_W-1:0];
    else if (sum_wide[wrh_pkg::SUM_W]) sum_sat = SUM_MIN;
    else sum_sat = SUM_MAX;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = sum_sat;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == ST_MOD && !is_read) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.op == wrh_pkg::OP_ACC || in_item.op == wrh_pkg::OP_READ) begin
            state_next = ST_MOD;
          end else if (in_item.op == wrh_pkg::OP_CLEAR) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_MOD:   state_next = ST_IDLE;
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      bpc_reg      <= wrh_pkg::BPC_RESET;
      sat_flag     <= 1'b0;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_MOD) && is_read;
      if (cfg_we) bpc_reg <= cfg_wdata;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (accept && in_item.op == wrh_pkg::OP_CLEAR) begin
        sat_flag <= 1'b0;
        clr_addr <= '0;
      end
      if (state == ST_MOD && !is_read && overflow) sat_flag <= 1'b1;
    end
  end

  // item payload held for the modify cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      idx      <= rd_addr;
      is_read  <= (in_item.op == wrh_pkg::OP_READ);
      weight   <= in_item.weight;
      in_range <= (16'(in_item.bin_index) >> (4'(bpc) * 4'd3)) == 16'd0;
      cen_r    <= wrh_pkg::center_q16(
                    (in_item.bin_index >> (4'(bpc) << 1)) & wrh_pkg::code_mask(bpc), bpc);
      cen_g    <= wrh_pkg::center_q16(
                    (in_item.bin_index >> bpc) & wrh_pkg::code_mask(bpc), bpc);
      cen_b    <= wrh_pkg::center_q16(in_item.bin_index & wrh_pkg::code_mask(bpc), bpc);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MOD && is_read) begin
      result.saturated <= sat_flag;
      if (in_range) begin
        result.bin_weight   <= mem_q;
        result.center_red   <= cen_r;
        result.center_green <= cen_g;
        result.center_blue  <= cen_b;
      end else begin
        result.bin_weight   <= '0;
        result.center_red   <= '0;
        result.center_green <= '0;
        result.center_blue  <= '0;
      end
    end
  end

endmodule
